// File: hw/rtl/hid_boot_keyboard_report_builder_unit_defines.svh
// Assertion macros for the boot keyboard report builder checker.
// Used by files that write concurrent assertions; no other dependencies.
`ifndef HID_BOOT_KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH
`define HID_BOOT_KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HBKR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define HBKR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hbkr_pkg.sv
// Shared constants and types for the boot keyboard report builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hbkr_pkg;

    localparam int SLOT_COUNT = 6;
    localparam int CODE_W     = 8;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int OUT_DATA_W = CODE_W * (SLOT_COUNT + 1);

    localparam logic [CODE_W-1:0] NO_KEY        = 8'h00;
    localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;
    localparam logic [CODE_W-1:0] MOD_FIRST     = 8'hE0;

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        code_t code;
        logic  pressed;
        logic  last;
    } item_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0][CODE_W-1:0] slots;
        code_t                             modifier_bits;
        logic                              overflowed;
    } report_t;

    // Usage codes 0xE0..0xE7 are the eight modifier keys.
    function automatic logic is_modifier(input code_t code);
        return code[CODE_W-1:3] == MOD_FIRST[CODE_W-1:3];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hbkr_in_stage.sv
// Input register for one key request; holds it until the accumulator takes it.
// Depends on hbkr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbkr_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire hbkr_pkg::item_t in_item,
    output logic                in_ready,
    input  wire logic           out_free,
    output logic                step,
    output hbkr_pkg::item_t     item
);
    import hbkr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // A last item can only move on when the report register is free.
    assign step     = valid_reg && (!item_reg.last || out_free);
    assign in_ready = !valid_reg || step;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (step)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hbkr_accum.sv
// Scan accumulator: modifier byte, six key slots, fill count, rollover flag.
// Depends on hbkr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbkr_accum (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire hbkr_pkg::item_t item,
    output logic                 report_valid,
    output hbkr_pkg::report_t    report
);
    import hbkr_pkg::*;

    code_t                             mod_reg, mod_next, mod_upd;
    logic [SLOT_COUNT-1:0][CODE_W-1:0] slots_reg, slots_next, slots_upd;
    logic [CNT_W-1:0]                  used_reg, used_next, used_upd;
    logic                              roll_reg, roll_next, roll_upd;

    always_comb
    begin
        mod_upd   = mod_reg;
        slots_upd = slots_reg;
        used_upd  = used_reg;
        roll_upd  = roll_reg;
        if (step && item.pressed && !roll_reg && item.code != NO_KEY)
        begin
            if (is_modifier(item.code))
            begin
                mod_upd = mod_reg | (code_t'(1) << item.code[2:0]);
            end
            else if (used_reg < CNT_W'(SLOT_COUNT))
            begin
                for (int k = 0; k < SLOT_COUNT; k++)
                begin
                    if (used_reg == CNT_W'(k))
                    begin
                        slots_upd[k] = item.code;
                    end
                end
                used_upd = used_reg + CNT_W'(1);
            end
            else
            begin
                // seventh ordinary key: error rollover, rest of scan ignored
                for (int k = 0; k < SLOT_COUNT; k++)
                begin
                    slots_upd[k] = ROLLOVER_CODE;
                end
                roll_upd = 1'b1;
            end
        end
    end

    assign report_valid         = step && item.last;
    assign report.modifier_bits = mod_upd;
    assign report.slots         = slots_upd;
    assign report.overflowed    = roll_upd;

    always_comb
    begin
        if (report_valid)
        begin
            mod_next   = '0;
            slots_next = '0;
            used_next  = '0;
            roll_next  = 1'b0;
        end
        else
        begin
            mod_next   = mod_upd;
            slots_next = slots_upd;
            used_next  = used_upd;
            roll_next  = roll_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= '0;
            slots_reg <= '0;
            used_reg  <= '0;
            roll_reg  <= 1'b0;
        end
        else
        begin
            mod_reg   <= mod_next;
            slots_reg <= slots_next;
            used_reg  <= used_next;
            roll_reg  <= roll_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hbkr_out_stage.sv
// Report register on the master side; holds a report until it is taken.
// Depends on hbkr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbkr_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              report_valid,
    input  wire hbkr_pkg::report_t report,
    output logic                   out_free,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [hbkr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser
);
    import hbkr_pkg::*;

    logic    valid_reg;
    report_t report_reg;

    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {report_reg.slots, report_reg.modifier_bits};
    assign m_axis_tuser  = report_reg.overflowed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= report_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && report_valid)
        begin
            report_reg <= report;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hid_boot_keyboard_report_builder_unit.sv
// Top level of the boot keyboard report builder: input register, accumulator,
// report register. Depends on hbkr_pkg, hbkr_in_stage, hbkr_accum, hbkr_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Takes one key request per cycle while s_axis_tready is high (usage code,
// pressed flag, tlast at end of scan) and sends one 7-byte boot keyboard
// report per scan. A key request is registered in the input register and then
// applied by the accumulator; the report is registered in the output register.
// s_axis_tready stays high except when a finished report is still held in
// the output register and the input register holds the end of the next scan.
module hid_boot_keyboard_report_builder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] usage_code
    input  wire logic        s_axis_tuser,   // [0] pressed
    input  wire logic        s_axis_tlast,   // end of scan
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [hbkr_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [7:0] modifier_bits,
                             // [15:8] slot_zero .. [55:48] slot_five
    output logic             m_axis_tuser    // [0] overflowed
);
    import hbkr_pkg::*;

    item_t   in_item;
    item_t   item;
    report_t report;
    logic    step;
    logic    out_free;
    logic    report_valid;

    assign in_item.code    = s_axis_tdata;
    assign in_item.pressed = s_axis_tuser;
    assign in_item.last    = s_axis_tlast;

    hbkr_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_item  (in_item),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    hbkr_accum u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (item),
        .report_valid (report_valid),
        .report       (report)
    );

    hbkr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .report_valid  (report_valid),
        .report        (report),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: hw/rtl/hbkr_checker.sv
// Port-level checks on the report builder, bound to the top level.
// Depends on hbkr_pkg and hid_boot_keyboard_report_builder_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "hid_boot_keyboard_report_builder_unit_defines.svh"

module hbkr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [hbkr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tuser
);
    import hbkr_pkg::*;

    logic [SLOT_COUNT-1:0][CODE_W-1:0] slot_codes;
    logic [OUT_DATA_W:0]               out_word;
    logic                              stalled;
    logic                              rollover_out;
    logic                              all_rollover;
    logic                              slots_packed;
    logic                              mod_in_slot;

    assign slot_codes   = m_axis_tdata[OUT_DATA_W-1:CODE_W];
    assign out_word     = {m_axis_tuser, m_axis_tdata};
    assign stalled      = m_axis_tvalid && !m_axis_tready;
    assign rollover_out = m_axis_tvalid && m_axis_tuser;

    always_comb
    begin
        all_rollover = 1'b1;
        slots_packed = 1'b1;
        mod_in_slot  = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (slot_codes[k] != ROLLOVER_CODE)
            begin
                all_rollover = 1'b0;
            end
            if (is_modifier(slot_codes[k]))
            begin
                mod_in_slot = 1'b1;
            end
        end
        for (int k = 1; k < SLOT_COUNT; k++)
        begin
            if (slot_codes[k-1] == NO_KEY && slot_codes[k] != NO_KEY)
            begin
                slots_packed = 1'b0;
            end
        end
    end

    `HBKR_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(out_word), "held report moved")

    // rollover report carries the error code in every slot
    `HBKR_ASSERT_NOW(a_rollover_fill, rollover_out, all_rollover, "rollover slots wrong")

    // slots fill in order: an empty slot is never followed by a used one
    `HBKR_ASSERT_NOW(a_no_gaps, m_axis_tvalid, slots_packed, "gap in key slots")

    // modifier codes never land in a key slot
    `HBKR_ASSERT_NOW(a_no_mod_slot, m_axis_tvalid, !mod_in_slot, "modifier code in key slot")

endmodule

bind hid_boot_keyboard_report_builder_unit hbkr_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
